// ----- rtl/kotpp_pkg.sv -----
// ----------------------------------------------------------------------------
// kotpp_pkg
// Shared types and constants of the keyed object table payload packer.
// ----------------------------------------------------------------------------
`default_nettype none

package kotpp_pkg;

	localparam int FUNC_W  = 1;
	localparam int KEY_W   = 8;
	localparam int VALUE_W = 16;
	localparam int LEN_W   = 2;
	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 4;
	localparam int LIMIT_W = 5;

	localparam int DEFAULT_MAX_ENTRIES       = 8;
	localparam int DEFAULT_MAX_PAYLOAD_BYTES = 24;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET      = 5'd24;
	localparam logic [BYTE_W-1:0]  DEVICE_INFO_BYTE = 8'h40;

	localparam logic [FUNC_W-1:0] FUNC_SET  = 1'b0;
	localparam logic [FUNC_W-1:0] FUNC_EMIT = 1'b1;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_BYTE   = 1'b1;

	localparam logic [LEN_W-1:0] LEN_ONE = 2'd1;
	localparam logic [LEN_W-1:0] LEN_TWO = 2'd2;

	typedef struct packed {
		logic               wide;
		logic [VALUE_W-1:0] value;
		logic [KEY_W-1:0]   key;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESP,
		ST_HDR,
		ST_KEY,
		ST_LO,
		ST_HI
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/kotpp_if.sv -----
// ----------------------------------------------------------------------------
// kotpp_if
// Ready/valid channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface kotpp_item_if;
	logic                             valid;
	logic                             ready;
	logic [kotpp_pkg::FUNC_W-1:0]     func;
	logic [kotpp_pkg::KEY_W-1:0]      object_key;
	logic [kotpp_pkg::VALUE_W-1:0]    object_value;
	logic [kotpp_pkg::LEN_W-1:0]      value_length;

	modport source (output valid, func, object_key, object_value, value_length, input ready);
	modport sink (input valid, func, object_key, object_value, value_length, output ready);
endinterface

interface kotpp_result_if;
	logic                             valid;
	logic                             ready;
	logic                             result_kind;
	logic                             accepted;
	logic [kotpp_pkg::BYTE_W-1:0]     payload_byte;
	logic                             last;
	logic [kotpp_pkg::COUNT_W-1:0]    entry_count;

	modport source (output valid, result_kind, accepted, payload_byte, last, entry_count,
		input ready);
	modport sink (input valid, result_kind, accepted, payload_byte, last, entry_count,
		output ready);
endinterface

`default_nettype wire

// ----- rtl/kotpp_ram.sv -----
// ----------------------------------------------------------------------------
// kotpp_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module kotpp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/keyed_object_table_payload_packer_unit.sv -----
// ----------------------------------------------------------------------------
// keyed_object_table_payload_packer_unit
// Keyed table of telemetry objects in a RAM, updated by set items and
// serialized into a payload byte stream by emit items.
// ----------------------------------------------------------------------------
//  Channel  Dir  Protocol      Transfer carries
//  item     in   valid/ready   func, object_key, object_value, value_length
//  result   out  valid/ready   result_kind, accepted, payload_byte, last, entry_count
//  cfg      in   write enable  payload_limit
//
//  One item is worked on at a time. A set compares its key with each stored
//  entry in turn, as the key search reads the table RAM one entry a cycle.
//  An emit gives one payload byte per cycle while the result is taken; the next
//  entry is read while the current one is sent. Result stalls hold the sequencer
//  in place, and the output register lets a new item in while the final result
//  waits. Reset empties the table; entries are never cleared otherwise.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_object_table_payload_packer_unit #(
	parameter int MAX_ENTRIES       = kotpp_pkg::DEFAULT_MAX_ENTRIES,
	parameter int MAX_PAYLOAD_BYTES = kotpp_pkg::DEFAULT_MAX_PAYLOAD_BYTES
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_write_en,
	input  wire logic [kotpp_pkg::LIMIT_W-1:0] cfg_write_data,
	kotpp_item_if.sink                         item,
	kotpp_result_if.source                     result
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int UW = $clog2(MAX_PAYLOAD_BYTES + 4);
	localparam int EW = $bits(kotpp_pkg::entry_t);

	kotpp_pkg::state_t state_q, state_d;

	logic [kotpp_pkg::LIMIT_W-1:0] limit_q;
	logic [CW-1:0]                 count_q;
	logic [CW-1:0]                 cand_q;
	logic [UW-1:0]                 used_q;
	logic                          ok_q;
	logic [kotpp_pkg::KEY_W-1:0]   req_key_q;
	logic [kotpp_pkg::VALUE_W-1:0] req_value_q;
	logic                          req_wide_q;
	kotpp_pkg::entry_t             cur_q;

	logic                          out_valid_q;
	logic                          out_kind_q;
	logic                          out_acc_q;
	logic [kotpp_pkg::BYTE_W-1:0]  out_byte_q;
	logic                          out_last_q;
	logic [kotpp_pkg::COUNT_W-1:0] out_count_q;

	logic                          accept;
	logic                          slot_free;
	logic                          len_ok;
	logic [kotpp_pkg::VALUE_W-1:0] in_value;
	logic [UW-1:0]                 limit_eff;
	logic [EW-1:0]                 rd_data;
	kotpp_pkg::entry_t             rd_entry;
	logic [CW-1:0]                 cand_nxt;
	logic                          cand_has;
	logic                          next_fits;
	logic                          key_match;
	logic                          table_full;

	logic                          rd_en;
	logic [AW-1:0]                 rd_addr;
	logic                          wr_en;
	logic [AW-1:0]                 wr_addr;
	kotpp_pkg::entry_t             wr_entry;
	logic                          cnt_inc;
	logic                          cand_clr;
	logic                          take;
	logic                          ok_load;
	logic                          ok_d;
	logic                          push;
	logic                          push_kind;
	logic                          push_acc;
	logic [kotpp_pkg::BYTE_W-1:0]  push_byte;
	logic                          push_last;

	assign item.ready = (state_q == kotpp_pkg::ST_IDLE);
	assign accept     = item.valid && item.ready;
	assign slot_free  = !out_valid_q || result.ready;
	assign len_ok     = (item.value_length == kotpp_pkg::LEN_ONE)
		|| (item.value_length == kotpp_pkg::LEN_TWO);
	assign in_value   = (item.value_length == kotpp_pkg::LEN_ONE)
		? {8'h00, item.object_value[7:0]} : item.object_value;

	always_comb begin
		if (32'(limit_q) > MAX_PAYLOAD_BYTES) begin
			limit_eff = UW'(MAX_PAYLOAD_BYTES);
		end else begin
			limit_eff = UW'(limit_q);
		end
	end

	assign rd_entry   = kotpp_pkg::entry_t'(rd_data);
	assign cand_nxt   = cand_q + CW'(1);
	assign cand_has   = cand_q < count_q;
	assign next_fits  = cand_has && ((used_q + UW'(2) + UW'(rd_entry.wide)) <= limit_eff);
	assign key_match  = rd_entry.key == req_key_q;
	assign table_full = !(count_q < CW'(MAX_ENTRIES));

	kotpp_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_ENTRIES)
	) u_table (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_entry),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kotpp_pkg::ST_IDLE: begin
				if (accept) begin
					if (item.func == kotpp_pkg::FUNC_SET) begin
						if (len_ok && (count_q != '0)) begin
							state_d = kotpp_pkg::ST_SCAN;
						end else begin
							state_d = kotpp_pkg::ST_RESP;
						end
					end else if ((count_q == '0) || (limit_eff == '0)) begin
						state_d = kotpp_pkg::ST_RESP;
					end else begin
						state_d = kotpp_pkg::ST_HDR;
					end
				end
			end
			kotpp_pkg::ST_SCAN: begin
				if (key_match || !(cand_nxt < count_q)) begin
					state_d = kotpp_pkg::ST_RESP;
				end
			end
			kotpp_pkg::ST_RESP: begin
				if (slot_free) begin
					state_d = kotpp_pkg::ST_IDLE;
				end
			end
			kotpp_pkg::ST_HDR, kotpp_pkg::ST_HI: begin
				if (slot_free) begin
					state_d = next_fits ? kotpp_pkg::ST_KEY : kotpp_pkg::ST_IDLE;
				end
			end
			kotpp_pkg::ST_KEY: begin
				if (slot_free) begin
					state_d = kotpp_pkg::ST_LO;
				end
			end
			kotpp_pkg::ST_LO: begin
				if (slot_free) begin
					if (cur_q.wide) begin
						state_d = kotpp_pkg::ST_HI;
					end else begin
						state_d = next_fits ? kotpp_pkg::ST_KEY : kotpp_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = kotpp_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = '0;
		wr_en     = 1'b0;
		wr_addr   = cand_q[AW-1:0];
		wr_entry  = '{wide: req_wide_q, value: req_value_q, key: req_key_q};
		cnt_inc   = 1'b0;
		cand_clr  = 1'b0;
		take      = 1'b0;
		ok_load   = 1'b0;
		ok_d      = 1'b0;
		push      = 1'b0;
		push_kind = kotpp_pkg::KIND_BYTE;
		push_acc  = 1'b1;
		push_byte = '0;
		push_last = 1'b0;
		unique case (state_q)
			kotpp_pkg::ST_IDLE: begin
				if (accept) begin
					ok_load = 1'b1;
					if (item.func == kotpp_pkg::FUNC_SET) begin
						if (len_ok && (count_q == '0)) begin
							wr_en    = 1'b1;
							wr_addr  = '0;
							wr_entry = '{wide: (item.value_length == kotpp_pkg::LEN_TWO),
								value: in_value, key: item.object_key};
							cnt_inc  = 1'b1;
							ok_d     = 1'b1;
						end else if (len_ok) begin
							rd_en    = 1'b1;
							cand_clr = 1'b1;
						end
					end else if ((count_q != '0) && (limit_eff != '0)) begin
						rd_en    = 1'b1;
						cand_clr = 1'b1;
					end
				end
			end
			kotpp_pkg::ST_SCAN: begin
				if (key_match) begin
					wr_en   = 1'b1;
					ok_load = 1'b1;
					ok_d    = 1'b1;
				end else if (cand_nxt < count_q) begin
					rd_en   = 1'b1;
					rd_addr = cand_nxt[AW-1:0];
					take    = 1'b1;
				end else if (!table_full) begin
					wr_en   = 1'b1;
					wr_addr = count_q[AW-1:0];
					cnt_inc = 1'b1;
					ok_load = 1'b1;
					ok_d    = 1'b1;
				end else begin
					ok_load = 1'b1;
				end
			end
			kotpp_pkg::ST_RESP: begin
				push      = slot_free;
				push_kind = kotpp_pkg::KIND_STATUS;
				push_acc  = ok_q;
				push_last = 1'b1;
			end
			kotpp_pkg::ST_HDR: begin
				push      = slot_free;
				push_byte = kotpp_pkg::DEVICE_INFO_BYTE;
				push_last = !next_fits;
				take      = slot_free && next_fits;
			end
			kotpp_pkg::ST_KEY: begin
				push      = slot_free;
				push_byte = cur_q.key;
			end
			kotpp_pkg::ST_LO: begin
				push      = slot_free;
				push_byte = cur_q.value[7:0];
				push_last = !cur_q.wide && !next_fits;
				take      = slot_free && !cur_q.wide && next_fits;
			end
			kotpp_pkg::ST_HI: begin
				push      = slot_free;
				push_byte = cur_q.value[15:8];
				push_last = !next_fits;
				take      = slot_free && next_fits;
			end
			default: begin
				push = 1'b0;
			end
		endcase
		if (take && (state_q != kotpp_pkg::ST_SCAN)) begin
			rd_en   = cand_nxt < count_q;
			rd_addr = cand_nxt[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kotpp_pkg::ST_IDLE;
			limit_q     <= kotpp_pkg::LIMIT_RESET;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write_en) begin
				limit_q <= cfg_write_data;
			end
			if (cnt_inc) begin
				count_q <= count_q + CW'(1);
			end
			if (slot_free) begin
				out_valid_q <= push;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_key_q   <= item.object_key;
			req_value_q <= in_value;
			req_wide_q  <= (item.value_length == kotpp_pkg::LEN_TWO);
		end
		if (ok_load) begin
			ok_q <= ok_d;
		end
		if (cand_clr) begin
			cand_q <= '0;
			used_q <= UW'(1);
		end else if (take) begin
			cand_q <= cand_nxt;
			if (state_q != kotpp_pkg::ST_SCAN) begin
				cur_q  <= rd_entry;
				used_q <= used_q + UW'(2) + UW'(rd_entry.wide);
			end
		end
		if (push) begin
			out_kind_q  <= push_kind;
			out_acc_q   <= push_acc;
			out_byte_q  <= push_byte;
			out_last_q  <= push_last;
			out_count_q <= kotpp_pkg::COUNT_W'(count_q);
		end
	end

	assign result.valid        = out_valid_q;
	assign result.result_kind  = out_kind_q;
	assign result.accepted     = out_acc_q;
	assign result.payload_byte = out_byte_q;
	assign result.last         = out_last_q;
	assign result.entry_count  = out_count_q;

endmodule

`default_nettype wire
